// ===== rtl/lrs_pkg.sv =====
// lrs_pkg: shared types and constants for the linear interpolation resampler.
// No dependencies; used by every module in rtl/.

package lrs_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned STEP_W   = 20;
  localparam int unsigned PHASE_W  = 21;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned DIFF_W   = SAMPLE_W + 1;
  localparam int unsigned PROD_W   = 2 * DIFF_W;
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QAW      = 2;
  localparam int unsigned QCNT_W   = QAW + 1;

  localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(65536);
  localparam logic [STEP_W-1:0]  STEP_MIN   = STEP_W'(1024);
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(65536);

  // input function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_of_run;
  } out_item_t;

  // what the front end decided an item is
  typedef enum logic [1:0] {
    KIND_FLUSH = 2'd0,
    KIND_FIRST = 2'd1,
    KIND_RUN   = 2'd2
  } q_kind_t;

  typedef struct packed {
    q_kind_t                    kind;
    logic signed [SAMPLE_W-1:0] prev;
    logic signed [SAMPLE_W-1:0] cur;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

// ===== rtl/lrs_queue.sv =====
// lrs_queue: small register FIFO between the front end and the interpolation engine.
// Depends on lrs_pkg.

module lrs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  lrs_pkg::q_push_t push,
  input  logic             pop,
  output lrs_pkg::q_head_t head,
  output logic             full
);
  import lrs_pkg::*;

  q_entry_t          mem_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[QAW-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ===== rtl/lrs_front.sv =====
// lrs_front: accepts items, tracks the stored sample and classifies each item.
// Depends on lrs_pkg; feeds lrs_queue.

module lrs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lrs_pkg::in_item_t in_data,
  input  logic              q_full,
  output lrs_pkg::q_push_t  push
);
  import lrs_pkg::*;

  logic                       have_first_r, have_first_nxt;
  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic                       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    have_first_nxt   = have_first_r;
    prev_nxt         = prev_r;
    push.valid       = accept;
    push.entry.kind  = KIND_RUN;
    push.entry.prev  = prev_r;
    push.entry.cur   = in_data.sample_in;
    if (accept) begin
      priority if (in_data.func == FUNC_FLUSH) begin
        push.entry.kind = KIND_FLUSH;
        have_first_nxt  = 1'b0;
        prev_nxt        = '0;
      end else if (!have_first_r) begin
        push.entry.kind = KIND_FIRST;
        have_first_nxt  = 1'b1;
        prev_nxt        = in_data.sample_in;
      end else begin
        prev_nxt        = in_data.sample_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_first_r <= 1'b0;
      prev_r       <= '0;
    end else begin
      have_first_r <= have_first_nxt;
      prev_r       <= prev_nxt;
    end
  end

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.func == FUNC_FLUSH) |=> (!have_first_r && prev_r == '0))
    else $error("flush did not clear stored sample");

  a_first_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && push.entry.kind == KIND_RUN) |-> have_first_r)
    else $error("run queued without a stored sample");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push.valid)
    else $error("push into full queue");

endmodule

// ===== rtl/lrs_back.sv =====
// lrs_back: interpolation engine; walks the phase, multiplies, shifts and adds.
// Depends on lrs_pkg; drains lrs_queue.

module lrs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lrs_pkg::STEP_W-1:0] phase_step,
  input  lrs_pkg::q_head_t           head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lrs_pkg::out_item_t         out_data
);
  import lrs_pkg::*;

  logic [PHASE_W-1:0]         phase_acc_r, phase_acc_nxt;
  logic [STEP_W-1:0]          step_eff;
  logic [PHASE_W-1:0]         phase_sum;
  logic                       is_run, emit, last, issue, issue_ok, out_load;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [DIFF_W-1:0]   frac_s;
  logic signed [PROD_W-1:0]   prod;

  // multiply stage
  logic                       s1_valid_r;
  logic signed [PROD_W-1:0]   s1_prod_r;
  logic signed [SAMPLE_W-1:0] s1_prev_r;
  logic                       s1_last_r;

  // output register
  logic                       out_valid_r;
  out_item_t                  out_data_r;
  logic signed [PROD_W-FRAC_W-1:0] shifted;
  logic signed [PROD_W-FRAC_W-1:0] interp;

  assign step_eff  = (phase_step < STEP_MIN) ? STEP_MIN : phase_step;
  assign phase_sum = phase_acc_r + PHASE_W'(step_eff);
  assign last      = (phase_sum >= PHASE_ONE);

  assign out_load = !out_valid_r || !out_stall;
  assign issue_ok = !s1_valid_r || out_load;
  assign is_run   = head.valid && (head.entry.kind == KIND_RUN);
  assign emit     = is_run && (phase_acc_r < PHASE_ONE);
  assign issue    = emit && issue_ok;
  // step >= 1024 keeps a run at 64 outputs at most, so no output counter
  assign pop      = head.valid && (!emit || (issue && last));

  assign diff   = DIFF_W'(head.entry.cur) - DIFF_W'(head.entry.prev);
  assign frac_s = $signed({1'b0, phase_acc_r[FRAC_W-1:0]});
  assign prod   = diff * frac_s;

  always_comb begin
    phase_acc_nxt = phase_acc_r;
    if (head.valid) begin
      unique case (head.entry.kind)
        KIND_FLUSH, KIND_FIRST: phase_acc_nxt = '0;
        KIND_RUN: begin
          if (!emit) begin
            phase_acc_nxt = phase_acc_r - PHASE_ONE;
          end else if (issue) begin
            phase_acc_nxt = last ? phase_sum - PHASE_ONE : phase_sum;
          end
        end
        default: phase_acc_nxt = phase_acc_r;
      endcase
    end
  end

  // floor shift of the product, then add the older sample
  assign shifted = s1_prod_r[PROD_W-1:FRAC_W];
  assign interp  = shifted + (PROD_W-FRAC_W)'(s1_prev_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_acc_r <= phase_acc_nxt;
      if (issue_ok) begin
        s1_valid_r <= issue;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_ok) begin
      s1_prod_r <= prod;
      s1_prev_r <= head.entry.prev;
      s1_last_r <= last;
    end
    if (out_load) begin
      out_data_r.sample_out  <= interp[SAMPLE_W-1:0];
      out_data_r.last_of_run <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_issue_phase: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> phase_acc_r < PHASE_ONE)
    else $error("output issued with phase at or above 1.0");

  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.entry.kind != KIND_RUN) |=> phase_acc_r == '0)
    else $error("phase not cleared on flush or first sample");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !issue_ok) |=> (s1_valid_r && $stable(s1_prod_r) && $stable(s1_last_r)))
    else $error("multiply stage lost data under stall");

endmodule

// ===== rtl/linear_interp_resampler.sv =====
// linear_interp_resampler: top level; step register, front end, queue, engine.
// Depends on lrs_pkg, lrs_front, lrs_queue, lrs_back.

// Resamples a stream of signed 16-bit audio by linear interpolation. Write the
// 4.16 step (source positions per output, 20 bits, reset 1.0) on the cfg
// channel while the block is idle; steps below 1/64 act as 1/64. Each input
// transfer carries either a sample or a flush. The first sample after reset or
// flush is only stored; every later sample closes the interval from the stored
// sample and yields one output per phase position below 1.0, the last of those
// flagged with last_of_run. A flush clears the stored sample and the phase and
// yields nothing. Input transfers are taken at one per cycle into a four-entry
// queue while it is not full; the engine behind it produces one output per
// cycle while the receiver does not stall, so an upsampling sample occupies
// it while it issues its outputs (up to 64), and a sample causing no output,
// a first sample or a flush is popped without waiting on the receiver. The
// multiply is registered: an output passes the multiply stage and then the
// output register. Once both hold results, a receiver stall halts the engine
// in that same cycle; while either is empty, it can still issue outputs.

module linear_interp_resampler (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lrs_pkg::STEP_W-1:0] cfg_data,
  // sample input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lrs_pkg::in_item_t          in_data,
  // interpolated output
  output logic                       out_valid,
  input  logic                       out_stall,
  output lrs_pkg::out_item_t         out_data
);
  import lrs_pkg::*;

  logic [STEP_W-1:0] phase_step_r, phase_step_nxt;
  q_push_t           push;
  q_head_t           head;
  logic              q_full;
  logic              pop;

  // step register, always writable
  assign cfg_ready      = 1'b1;
  assign phase_step_nxt = (cfg_valid && cfg_ready) ? cfg_data : phase_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= STEP_RESET;
    end else begin
      phase_step_r <= phase_step_nxt;
    end
  end

  // front end: classify each transfer, keep the previous sample
  lrs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push)
  );

  // decoupling queue
  lrs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  // engine: phase walk, multiply, shift and add
  lrs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .phase_step (phase_step_r),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench for linear_interp_resampler; runs directed and random
// sample/flush streams under several step settings. Depends on lrs_pkg and the RTL top.

module tb_top;
  import lrs_pkg::*;

  localparam int unsigned TAIL_CYCLES  = 24;
  localparam int unsigned RANDOM_ITEMS = 350;
  localparam int unsigned MAX_RUN      = 64;

  typedef struct {
    in_item_t item;
    bit       drain_first;  // hold this item until every expected output has arrived
  } stim_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [STEP_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;

  stim_t     stim_q[$];
  out_item_t expected_q[$];

  // predictor state
  logic [STEP_W-1:0]          step_reg;
  logic signed [SAMPLE_W-1:0] held_sample;
  logic [PHASE_W-1:0]         phase;
  bit                         have_first;

  int fail_count;
  int shown;
  int burst_left;
  int gap_left;
  int stall_mode;
  int stall_left;

  linear_interp_resampler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Expected outputs for one accepted transfer; updates the predictor state.
  function automatic void interpolate_sample(in_item_t it);
    logic [STEP_W-1:0] eff_step;
    longint            diff;
    longint            y;
    int                n;
    out_item_t         o;
    if (it.func == FUNC_FLUSH) begin
      held_sample = '0;
      phase       = '0;
      have_first  = 1'b0;
      return;
    end
    if (!have_first) begin
      held_sample = it.sample_in;
      phase       = '0;
      have_first  = 1'b1;
      return;
    end
    eff_step = (step_reg < STEP_MIN) ? STEP_MIN : step_reg;
    diff = longint'($signed(it.sample_in)) - longint'($signed(held_sample));
    n = 0;
    while (phase < PHASE_ONE && n < MAX_RUN) begin
      // floor shift of the full-width product
      y = longint'($signed(held_sample)) + ((diff * longint'(phase[FRAC_W-1:0])) >>> 16);
      o.sample_out  = y[SAMPLE_W-1:0];
      o.last_of_run = 1'b0;
      expected_q.push_back(o);
      n++;
      phase = phase + PHASE_W'(eff_step);
    end
    if (n > 0) begin
      o = expected_q.pop_back();
      o.last_of_run = 1'b1;
      expected_q.push_back(o);
    end
    phase       = (phase >= PHASE_ONE) ? phase - PHASE_ONE : '0;
    held_sample = it.sample_in;
  endfunction

  function automatic void add_item(logic f, int s, bit drain);
    stim_t st;
    st.item.func      = f;
    st.item.sample_in = SAMPLE_W'(s);
    st.drain_first    = drain;
    stim_q.push_back(st);
  endfunction

  function automatic int rand_sample(int last);
    int s;
    case ($urandom_range(0, 5))
      0: s = $urandom_range(0, 1) ? 32767 : -32768;
      1, 2: s = int'($urandom_range(0, 65535)) - 32768;
      default: begin
        // slowly moving waveform
        s = last + int'($urandom_range(0, 2000)) - 1000;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
      end
    endcase
    return s;
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 7))
      0: return STEP_MIN;
      1: return STEP_W'($urandom_range(0, 1023));  // below the floor
      2: return '1;
      3: return STEP_RESET;
      4: return STEP_W'($urandom_range(1024, 20000));
      5: return STEP_W'($urandom_range(131072, 1048575));
      default: return STEP_W'($urandom_range(20000, 131072));
    endcase
  endfunction

  task automatic write_step(logic [STEP_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    step_reg = v;
  endtask

  // all transfers sent, all outputs seen, then let the pipeline settle
  task automatic wait_idle();
    do @(posedge clk); while (stim_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin : drive_inputs
    bit present;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      present = in_valid;
      if (in_valid && !in_stall) begin
        interpolate_sample(in_data);
        stim_q.delete(0);
        present = 1'b0;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (!present && stim_q.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!stim_q[0].drain_first || expected_q.size() == 0) begin
          present = 1'b1;
          in_data <= stim_q[0].item;
        end
      end
      in_valid <= present;
    end
  end

  // receiver: check each transfer, stall in randomly chosen modes of random length
  always @(posedge clk) begin : check_outputs
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("unexpected output: sample_out=%0d last_of_run=%0b",
                     out_data.sample_out, out_data.last_of_run);
          end
        end else begin
          want = expected_q.pop_front();
          if (want.sample_out !== out_data.sample_out ||
              want.last_of_run !== out_data.last_of_run) begin
            fail_count++;
            if (shown < 10) begin
              shown++;
              $display("mismatch: expected sample_out=%0d last_of_run=%0b, got %0d %0b",
                       want.sample_out, want.last_of_run,
                       out_data.sample_out, out_data.last_of_run);
            end
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(50, 300);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= ((stall_left % 5) < 2);
      endcase
    end
  end

  initial begin
    int                total;
    int                cnt;
    int                s;
    int                last_s;
    logic [STEP_W-1:0] st;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    rst_n       = 1'b0;
    fail_count  = 0;
    shown       = 0;
    burst_left  = 1;
    gap_left    = 0;
    stall_mode  = 0;
    stall_left  = 0;
    step_reg    = STEP_RESET;
    held_sample = '0;
    phase       = '0;
    have_first  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset step of 1.0: first sample stored only, full-scale swings, flushes
    add_item(FUNC_SAMPLE, 1000, 1'b0);
    add_item(FUNC_SAMPLE, 32767, 1'b0);
    add_item(FUNC_SAMPLE, -32768, 1'b0);
    add_item(FUNC_FLUSH, -1, 1'b0);
    add_item(FUNC_FLUSH, 0, 1'b0);
    add_item(FUNC_SAMPLE, -5, 1'b0);
    add_item(FUNC_SAMPLE, 7, 1'b1);
    wait_idle();

    // minimum step: 64 outputs per sample across full-scale intervals
    write_step(STEP_MIN);
    add_item(FUNC_SAMPLE, 32767, 1'b0);
    add_item(FUNC_SAMPLE, -32768, 1'b0);
    add_item(FUNC_SAMPLE, 32767, 1'b0);
    add_item(FUNC_SAMPLE, -1, 1'b0);
    add_item(FUNC_FLUSH, 12345, 1'b0);
    add_item(FUNC_SAMPLE, -12345, 1'b0);
    add_item(FUNC_SAMPLE, 12345, 1'b0);
    wait_idle();

    // steps below the floor act as the floor
    write_step('0);
    add_item(FUNC_SAMPLE, -100, 1'b0);
    add_item(FUNC_SAMPLE, 100, 1'b0);
    wait_idle();

    // largest step: mostly downsampling transfers with no output
    write_step('1);
    add_item(FUNC_SAMPLE, -32768, 1'b0);
    add_item(FUNC_SAMPLE, 32767, 1'b0);
    add_item(FUNC_SAMPLE, 0, 1'b0);
    add_item(FUNC_SAMPLE, 500, 1'b0);
    add_item(FUNC_SAMPLE, -500, 1'b0);
    add_item(FUNC_SAMPLE, 1, 1'b0);
    wait_idle();

    total  = 0;
    last_s = 0;
    while (total < RANDOM_ITEMS) begin
      st = pick_step();
      write_step(st);
      cnt = $urandom_range(20, 50);
      repeat (cnt) begin
        if ($urandom_range(0, 19) == 0) begin
          add_item(FUNC_FLUSH, $urandom_range(0, 65535), 1'b0);
        end else begin
          s = rand_sample(last_s);
          last_s = s;
          add_item(FUNC_SAMPLE, s, $urandom_range(0, 29) == 0);
        end
      end
      total += cnt;
      wait_idle();
    end

    fail_count += expected_q.size();
    if (fail_count == 0) begin
      $display("linear_interp_resampler verification clean");
    end else begin
      $display("linear_interp_resampler verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("linear_interp_resampler verification failed");
    $finish;
  end

endmodule
